// ===== design/klt_pkg.sv =====
// Shared types and codes for the keyed list table.
package klt_pkg;

    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_SEARCH = 2'd2;
    localparam logic [1:0] CMD_LIST   = 2'd3;

    localparam logic [2:0] ST_INSERTED = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_REMOVED  = 3'd2;
    localparam logic [2:0] ST_NOTFOUND = 3'd3;
    localparam logic [2:0] ST_FOUND    = 3'd4;
    localparam logic [2:0] ST_ENTRY    = 3'd5;
    localparam logic [2:0] ST_EMPTY    = 3'd6;

    typedef struct packed {
        logic [1:0]         cmd;
        logic [63:0]        key_w0;
        logic [63:0]        key_w1;
        logic [63:0]        key_w2;
        logic [63:0]        key_w3;
        logic [63:0]        kind_w0;
        logic [63:0]        kind_w1;
        logic [63:0]        kind_w2;
        logic signed [31:0] amount;
    } req_t;

    typedef struct packed {
        logic [2:0]         status;
        logic [3:0]         slot;
        logic [63:0]        out_key_w0;
        logic [63:0]        out_key_w1;
        logic [63:0]        out_key_w2;
        logic [63:0]        out_key_w3;
        logic [63:0]        out_kind_w0;
        logic [63:0]        out_kind_w1;
        logic [63:0]        out_kind_w2;
        logic signed [31:0] out_amount;
        logic [4:0]         entries;
        logic               last;
    } rsp_t;

    typedef struct packed {
        logic [63:0]        key_w0;
        logic [63:0]        key_w1;
        logic [63:0]        key_w2;
        logic [63:0]        key_w3;
        logic [63:0]        kind_w0;
        logic [63:0]        kind_w1;
        logic [63:0]        kind_w2;
        logic signed [31:0] amount;
    } record_t;

    localparam int REC_W = $bits(record_t);

endpackage

// ===== design/klt_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module klt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                   clk,
    input  logic                                   we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
    input  logic [WIDTH-1:0]                       wdata,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
    output logic [WIDTH-1:0]                       rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== design/keyed_list_table.sv =====
// Top level of the keyed list table: command sequencer, key comparator and record RAM.
//
// Records live in one RAM that is read one entry per cycle through a single
// 256-bit key comparator. Insert writes the record and answers from the idle
// state. Search compares the stored entries in slot order until a key matches
// or none is left. Remove takes the scan up to the match, then moves each
// later entry down by one slot. List emits one result per cycle from the
// registered RAM read data. Commands that find the table empty or full answer
// straight from the idle state. busy is high while a command runs; start is
// taken only when busy is low. Each result appears for exactly one cycle with
// rsp_valid high and cannot be held off; list results come on consecutive
// cycles, the final one of a command having last set.
module keyed_list_table #(
    parameter int CAPACITY = 16
) (
    input  logic          clk,
    input  logic          rst_n,
    input  logic          start,
    output logic          busy,
    input  klt_pkg::req_t req,
    output klt_pkg::rsp_t rsp,
    output logic          rsp_valid
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int CW = $clog2(CAPACITY + 1);
    localparam logic [CW-1:0] CAP = CW'(CAPACITY);

    typedef enum logic [3:0] {
        S_IDLE  = 4'b0001,
        S_SCAN  = 4'b0010,
        S_SHIFT = 4'b0100,
        S_LIST  = 4'b1000
    } state_t;

    state_t             state_reg, state_next;
    logic [AW-1:0]      idx_reg, idx_next;
    logic [AW-1:0]      hit_reg, hit_next;
    logic [CW-1:0]      cnt_reg, cnt_next;
    klt_pkg::req_t      req_reg, req_next;
    klt_pkg::record_t   hold_reg, hold_next;
    klt_pkg::rsp_t      rsp_reg, rsp_next;
    logic               rsp_valid_reg, rsp_valid_next;

    logic               we;
    logic [AW-1:0]      waddr;
    logic [AW-1:0]      raddr;
    klt_pkg::record_t   wdata;
    klt_pkg::record_t   rd_data;
    logic [CW-1:0]      idx_inc;
    logic               more;
    logic               match;
    klt_pkg::record_t   in_rec;
    klt_pkg::record_t   zero_rec;

    function automatic logic [3:0] fit_slot(input logic [AW-1:0] i);
        logic [AW+3:0] w;
        w = {4'b0, i};
        return w[3:0];
    endfunction

    function automatic logic [4:0] fit_cnt(input logic [CW-1:0] c);
        logic [CW+4:0] w;
        w = {5'b0, c};
        return w[4:0];
    endfunction

    function automatic klt_pkg::rsp_t make_rsp(
        input logic [2:0]       status,
        input logic [3:0]       slot,
        input klt_pkg::record_t r,
        input logic             last
    );
        klt_pkg::rsp_t o;
        o.status      = status;
        o.slot        = slot;
        o.out_key_w0  = r.key_w0;
        o.out_key_w1  = r.key_w1;
        o.out_key_w2  = r.key_w2;
        o.out_key_w3  = r.key_w3;
        o.out_kind_w0 = r.kind_w0;
        o.out_kind_w1 = r.kind_w1;
        o.out_kind_w2 = r.kind_w2;
        o.out_amount  = r.amount;
        o.entries     = 5'd0;
        o.last        = last;
        return o;
    endfunction

    klt_ram #(
        .WIDTH (klt_pkg::REC_W),
        .DEPTH (CAPACITY)
    ) u_ram (
        .clk   (clk),
        .we    (we),
        .waddr (waddr),
        .wdata (wdata),
        .raddr (raddr),
        .rdata (rd_data)
    );

    assign zero_rec = '0;
    assign in_rec.key_w0  = req.key_w0;
    assign in_rec.key_w1  = req.key_w1;
    assign in_rec.key_w2  = req.key_w2;
    assign in_rec.key_w3  = req.key_w3;
    assign in_rec.kind_w0 = req.kind_w0;
    assign in_rec.kind_w1 = req.kind_w1;
    assign in_rec.kind_w2 = req.kind_w2;
    assign in_rec.amount  = req.amount;

    assign idx_inc = CW'({{(CW - AW){1'b0}}, idx_reg}) + CW'(1);
    assign more    = (idx_inc < cnt_reg);
    assign match   = (rd_data.key_w0 == req_reg.key_w0) &&
                     (rd_data.key_w1 == req_reg.key_w1) &&
                     (rd_data.key_w2 == req_reg.key_w2) &&
                     (rd_data.key_w3 == req_reg.key_w3);

    assign busy      = (state_reg != S_IDLE);
    assign rsp       = rsp_reg;
    assign rsp_valid = rsp_valid_reg;

    always_comb
    begin
        state_next     = state_reg;
        idx_next       = idx_reg;
        hit_next       = hit_reg;
        cnt_next       = cnt_reg;
        req_next       = req_reg;
        hold_next      = hold_reg;
        rsp_next       = rsp_reg;
        rsp_valid_next = 1'b0;
        we             = 1'b0;
        waddr          = cnt_reg[AW-1:0];
        wdata          = in_rec;
        raddr          = (state_reg == S_IDLE) ? '0 : idx_reg + AW'(1);

        unique case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    req_next = req;
                    unique case (req.cmd)
                        klt_pkg::CMD_INSERT:
                        begin
                            rsp_valid_next = 1'b1;
                            if (cnt_reg == CAP)
                            begin
                                rsp_next = make_rsp(klt_pkg::ST_FULL, 4'd0, zero_rec, 1'b1);
                            end
                            else
                            begin
                                we       = 1'b1;
                                cnt_next = cnt_reg + CW'(1);
                                rsp_next = make_rsp(klt_pkg::ST_INSERTED,
                                                    fit_slot(cnt_reg[AW-1:0]), in_rec, 1'b1);
                            end
                        end
                        klt_pkg::CMD_REMOVE, klt_pkg::CMD_SEARCH:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = make_rsp(klt_pkg::ST_NOTFOUND, 4'd0, zero_rec, 1'b1);
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_SCAN;
                            end
                        end
                        klt_pkg::CMD_LIST:
                        begin
                            if (cnt_reg == '0)
                            begin
                                rsp_valid_next = 1'b1;
                                rsp_next = make_rsp(klt_pkg::ST_EMPTY, 4'd0, zero_rec, 1'b1);
                            end
                            else
                            begin
                                idx_next   = '0;
                                state_next = S_LIST;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_SCAN:
            begin
                if (match)
                begin
                    hold_next = rd_data;
                    hit_next  = idx_reg;
                    if (req_reg.cmd == klt_pkg::CMD_SEARCH)
                    begin
                        rsp_valid_next = 1'b1;
                        rsp_next   = make_rsp(klt_pkg::ST_FOUND, fit_slot(idx_reg),
                                              rd_data, 1'b1);
                        state_next = S_IDLE;
                    end
                    else if (more)
                    begin
                        idx_next   = idx_reg + AW'(1);
                        state_next = S_SHIFT;
                    end
                    else
                    begin
                        cnt_next       = cnt_reg - CW'(1);
                        rsp_valid_next = 1'b1;
                        rsp_next   = make_rsp(klt_pkg::ST_REMOVED, fit_slot(idx_reg),
                                              rd_data, 1'b1);
                        state_next = S_IDLE;
                    end
                end
                else if (more)
                begin
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    rsp_valid_next = 1'b1;
                    rsp_next   = make_rsp(klt_pkg::ST_NOTFOUND, 4'd0, zero_rec, 1'b1);
                    state_next = S_IDLE;
                end
            end
            S_SHIFT:
            begin
                // entry at idx moves down one slot
                we    = 1'b1;
                waddr = idx_reg - AW'(1);
                wdata = rd_data;
                if (more)
                begin
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    cnt_next       = cnt_reg - CW'(1);
                    rsp_valid_next = 1'b1;
                    rsp_next   = make_rsp(klt_pkg::ST_REMOVED, fit_slot(hit_reg),
                                          hold_reg, 1'b1);
                    state_next = S_IDLE;
                end
            end
            S_LIST:
            begin
                rsp_valid_next = 1'b1;
                rsp_next = make_rsp(klt_pkg::ST_ENTRY, fit_slot(idx_reg), rd_data, !more);
                if (more)
                begin
                    idx_next = idx_reg + AW'(1);
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        rsp_next.entries = fit_cnt(cnt_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cnt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            rsp_valid_reg <= rsp_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg  <= idx_next;
        hit_reg  <= hit_next;
        req_reg  <= req_next;
        hold_reg <= hold_next;
        rsp_reg  <= rsp_next;
    end

endmodule
